// ===== rtl/core/pwfp_pkg.sv =====
// Shared types and constants for the protobuf wire-format field parser.
package pwfp_pkg;

    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int CFG_WIDTH             = 32;
    localparam int VALUE_WIDTH           = 64;
    localparam int FIELD_WIDTH           = 32;

    typedef enum logic [2:0] {
        EV_TAG    = 3'd0,
        EV_VARINT = 3'd1,
        EV_LEN    = 3'd2,
        EV_SKIP   = 3'd3,
        EV_ERROR  = 3'd4
    } t_event_kind;

    typedef enum logic [2:0] {
        ER_NONE     = 3'd0,
        ER_OVERFLOW = 3'd1,
        ER_TRUNC    = 3'd2,
        ER_EXCEEDS  = 3'd3,
        ER_WIRE     = 3'd4,
        ER_PAST     = 3'd5
    } t_error_code;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    typedef struct packed {
        t_event_kind             event_kind;
        logic [FIELD_WIDTH-1:0]  field_id;
        logic [2:0]              wire_kind;
        logic [VALUE_WIDTH-1:0]  value;
        logic [VALUE_WIDTH-1:0]  value_zigzag;
        t_error_code             error_code;
        logic                    message_end;
    } t_result;

endpackage

// ===== rtl/core/pwfp_core.sv =====
// Parser state and the combinational step that decodes one message byte.
module pwfp_core
    import pwfp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_cfg_we,
    input  logic [CFG_WIDTH-1:0] i_cfg_data,
    output logic                 o_has_result,
    output t_result              o_result
);

    localparam int FIXED64_BYTES   = 8;
    localparam int FIXED32_BYTES   = 4;
    localparam int VARINT_MAX_SHIFT = 64;
    localparam int VARINT_STEP     = 7;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_VALUE,
        PH_LENGTH,
        PH_SKIP
    } t_phase;

    t_phase                   r_phase, n_phase;
    logic [VALUE_WIDTH-1:0]   r_acc, n_acc;
    logic [6:0]               r_shift, n_shift;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_skip, n_skip;
    logic [POSITION_BITS-1:0] r_msg_size;
    logic [FIELD_WIDTH-1:0]   r_field, n_field;
    logic [2:0]               r_wt, n_wt;
    logic                     r_err, n_err;

    logic [POSITION_BITS-1:0] w_pos_inc;
    logic [POSITION_BITS-1:0] w_remain;
    logic [POSITION_BITS-1:0] w_fixed_len;
    logic [POSITION_BITS-1:0] w_skip_dec;
    logic [POSITION_BITS-1:0] w_cfg_size;
    logic [VALUE_WIDTH-1:0]   w_acc;
    logic [6:0]               w_shift_next;
    logic                     w_at_end;
    t_event_kind              w_kind;
    t_error_code              w_code;
    logic [VALUE_WIDTH-1:0]   w_value;
    logic [VALUE_WIDTH-1:0]   w_zigzag;
    logic                     w_end;

    assign w_pos_inc    = r_pos + POSITION_BITS'(1);
    assign w_remain     = r_msg_size - w_pos_inc;
    assign w_at_end     = (w_pos_inc == r_msg_size);
    assign w_acc        = r_acc | (VALUE_WIDTH'(i_byte[6:0]) << r_shift[5:0]);
    assign w_shift_next = r_shift + 7'(VARINT_STEP);
    assign w_skip_dec   = (r_skip != '0) ? (r_skip - POSITION_BITS'(1)) : r_skip;
    assign w_fixed_len  = (w_acc[2:0] == WT_FIXED64) ? POSITION_BITS'(FIXED64_BYTES)
                                                     : POSITION_BITS'(FIXED32_BYTES);
    assign w_cfg_size   = (VALUE_WIDTH'(i_cfg_data) > VALUE_WIDTH'({POSITION_BITS{1'b1}}))
                        ? {POSITION_BITS{1'b1}} : POSITION_BITS'(i_cfg_data);

    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_shift      = r_shift;
        n_pos        = r_pos;
        n_skip       = r_skip;
        n_field      = r_field;
        n_wt         = r_wt;
        n_err        = r_err;
        o_has_result = 1'b0;
        w_kind       = EV_TAG;
        w_code       = ER_NONE;
        w_value      = '0;
        w_zigzag     = '0;
        w_end        = 1'b0;
        if (i_step && !r_err) begin
            if (r_pos >= r_msg_size) begin
                n_err        = 1'b1;
                o_has_result = 1'b1;
                w_kind       = EV_ERROR;
                w_code       = ER_PAST;
            end else begin
                n_pos = w_pos_inc;
                if (r_phase == PH_SKIP) begin
                    n_skip = w_skip_dec;
                    if (w_skip_dec == '0) begin
                        n_phase      = PH_TAG;
                        o_has_result = 1'b1;
                        w_kind       = EV_SKIP;
                        w_end        = w_at_end;
                    end
                end else if (i_byte[7]) begin
                    n_acc   = w_acc;
                    n_shift = w_shift_next;
                    if (w_shift_next >= 7'(VARINT_MAX_SHIFT)) begin
                        n_err        = 1'b1;
                        o_has_result = 1'b1;
                        w_kind       = EV_ERROR;
                        w_code       = ER_OVERFLOW;
                    end else if (w_at_end) begin
                        n_err        = 1'b1;
                        o_has_result = 1'b1;
                        w_kind       = EV_ERROR;
                        w_code       = ER_TRUNC;
                    end
                end else begin
                    n_acc        = '0;
                    n_shift      = '0;
                    o_has_result = 1'b1;
                    case (r_phase)
                        PH_TAG: begin
                            n_wt    = w_acc[2:0];
                            n_field = w_acc[FIELD_WIDTH+2:3];
                            w_kind  = EV_TAG;
                            case (w_acc[2:0])
                                WT_VARINT, WT_LEN: begin
                                    if (w_at_end) begin
                                        n_err  = 1'b1;
                                        w_kind = EV_ERROR;
                                        w_code = ER_TRUNC;
                                    end else begin
                                        n_phase = (w_acc[2:0] == WT_VARINT) ? PH_VALUE
                                                                             : PH_LENGTH;
                                    end
                                end
                                WT_FIXED64, WT_FIXED32: begin
                                    if (w_fixed_len > w_remain) begin
                                        n_err  = 1'b1;
                                        w_kind = EV_ERROR;
                                        w_code = ER_EXCEEDS;
                                    end else begin
                                        n_skip  = w_fixed_len;
                                        n_phase = PH_SKIP;
                                    end
                                end
                                default: begin
                                    n_err  = 1'b1;
                                    w_kind = EV_ERROR;
                                    w_code = ER_WIRE;
                                end
                            endcase
                        end
                        PH_VALUE: begin
                            n_phase  = PH_TAG;
                            w_kind   = EV_VARINT;
                            w_value  = w_acc;
                            w_zigzag = {1'b0, w_acc[VALUE_WIDTH-1:1]}
                                     ^ {VALUE_WIDTH{w_acc[0]}};
                            w_end    = w_at_end;
                        end
                        PH_LENGTH: begin
                            if (w_acc > VALUE_WIDTH'(w_remain)) begin
                                n_err  = 1'b1;
                                w_kind = EV_ERROR;
                                w_code = ER_EXCEEDS;
                            end else if (w_acc == '0) begin
                                n_phase = PH_TAG;
                                w_kind  = EV_LEN;
                                w_end   = w_at_end;
                            end else begin
                                n_skip  = POSITION_BITS'(w_acc);
                                n_phase = PH_SKIP;
                                w_kind  = EV_LEN;
                                w_value = w_acc;
                            end
                        end
                        default: begin
                            o_has_result = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always_comb begin
        o_result.event_kind   = w_kind;
        o_result.field_id     = n_field;
        o_result.wire_kind    = n_wt;
        o_result.value        = w_value;
        o_result.value_zigzag = w_zigzag;
        o_result.error_code   = w_code;
        o_result.message_end  = w_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG;
            r_acc      <= '0;
            r_shift    <= '0;
            r_pos      <= '0;
            r_skip     <= '0;
            r_msg_size <= '0;
            r_field    <= '0;
            r_wt       <= '0;
            r_err      <= 1'b0;
        end else if (i_cfg_we) begin
            r_phase    <= PH_TAG;
            r_acc      <= '0;
            r_shift    <= '0;
            r_pos      <= '0;
            r_skip     <= '0;
            r_msg_size <= w_cfg_size;
            r_field    <= '0;
            r_wt       <= '0;
            r_err      <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_shift <= n_shift;
            r_pos   <= n_pos;
            r_skip  <= n_skip;
            r_field <= n_field;
            r_wt    <= n_wt;
            r_err   <= n_err;
        end
    end

    a_no_result_when_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !o_has_result)
        else $error("result produced while an error is latched");

    a_pos_within_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_msg_size)
        else $error("byte position beyond message size");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip != '0))
        else $error("skip phase with nothing left to skip");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_err |-> (r_shift <= 7'(VARINT_MAX_SHIFT - 1)))
        else $error("varint shift out of range without an error");

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_pos == '0 && !r_err && r_phase == PH_TAG))
        else $error("configuration write did not restart parsing");

endmodule

// ===== rtl/core/protobuf_wire_field_parser_top.sv =====
// Top level of the protobuf wire-format field parser with its handshake registers.
//
// The parser takes one message byte per cycle while the output is not stalled and returns
// at most one event per byte: the byte is held in an input register, decoded in one step
// and the event is held in a result register, so a full stream runs at one byte per clock
// and a stalled output holds the input back only once both registers are occupied. The
// clock rate is set by the 64-bit shift-or of the varint accumulator and the length compare
// in that step. Writing message_size (the configuration channel is always ready) restarts
// parsing at position zero and clears a latched error; after an error no further events
// appear until then.
module protobuf_wire_field_parser_top
    import pwfp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_WIDTH-1:0]         i_message_size,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_data_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_event_kind,
    output logic [FIELD_WIDTH-1:0]       o_field_id,
    output logic [2:0]                   o_wire_kind,
    output logic [VALUE_WIDTH-1:0]       o_value,
    output logic signed [VALUE_WIDTH-1:0] o_value_zigzag,
    output logic [2:0]                   o_error_code,
    output logic                         o_message_end
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_out_free;
    logic       w_step;
    logic       w_cfg_we;
    logic       w_has_result;
    t_result    w_result;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_step      = r_in_valid && w_out_free;
    assign o_in_ready  = !r_in_valid || w_step;

    pwfp_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_byte       (r_in_byte),
        .i_cfg_we     (w_cfg_we),
        .i_cfg_data   (i_message_size),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= w_step && w_has_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
        end
        if (w_out_free) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_out.event_kind;
    assign o_field_id     = r_out.field_id;
    assign o_wire_kind    = r_out.wire_kind;
    assign o_value        = r_out.value;
    assign o_value_zigzag = $signed(r_out.value_zigzag);
    assign o_error_code   = r_out.error_code;
    assign o_message_end  = r_out.message_end;

    a_step_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out))
        else $error("pending event overwritten");

    a_error_code_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.event_kind == EV_ERROR) == (r_out.error_code != ER_NONE)))
        else $error("error code inconsistent with event kind");

    a_error_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.event_kind == EV_ERROR || r_out.event_kind == EV_TAG))
            |-> !r_out.message_end)
        else $error("message end flagged on a tag or error event");

endmodule
